@@ design/bfr_pkg.sv @@
// Package for the burst fragment reassembly block: payload structs, status codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
package bfr_pkg;

    // Reorder store geometry (power of two, so slot = index low bits)
    localparam int REORDER_DEPTH = 64;
    localparam int SLOT_BITS     = $clog2(REORDER_DEPTH);
    localparam int HANDLE_BITS   = 16;

    // Result status codes
    typedef enum logic [2:0] {
        ST_MERGED = 3'd0,
        ST_PARKED = 3'd1,
        ST_STALE  = 3'd2,
        ST_DUP    = 3'd3,
        ST_WINDOW = 3'd4,
        ST_EMPTY  = 3'd5
    } status_t;

    // One fragment descriptor
    typedef struct packed {
        logic [31:0]            burst_seq;
        logic [15:0]            frag_index;
        logic [15:0]            frag_count;
        logic [15:0]            frag_len;
        logic [HANDLE_BITS-1:0] frag_handle;
    } frag_in_t;

    // One result
    typedef struct packed {
        status_t                status;
        logic [15:0]            out_index;
        logic [HANDLE_BITS-1:0] out_handle;
        logic [15:0]            out_len;
        logic [31:0]            out_burst;
        logic [15:0]            merged_so_far;
        logic [31:0]            merged_total_bytes;
        logic                   burst_complete;
        logic                   last;
        logic [31:0]            fragments_seen;
        logic [31:0]            bursts_done;
    } frag_out_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_SCAN,
        S_HEAD,
        S_DRAIN_EMIT,
        S_DRAIN_RD
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic classify;
        logic scan_step;
        logic scan_finish;
        logic head_load;
        logic drain_load;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_merge;
        logic scan_stop;
        logic run_zero;
        logic drain_last;
        logic out_free;
    } dp_stat_t;

endpackage

@@ design/bfr_ctrl.sv @@
// Controller state machine for burst fragment reassembly.
// Depends on bfr_pkg (state_t, ctrl_cmd_t, dp_stat_t).
module bfr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bfr_pkg::dp_stat_t  stat,
    output bfr_pkg::ctrl_cmd_t cmd
);

    bfr_pkg::state_t state_reg;
    bfr_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bfr_pkg::S_CLASSIFY;
                end
            end
            bfr_pkg::S_CLASSIFY:
            begin
                if (stat.is_merge)
                begin
                    state_next = bfr_pkg::S_SCAN;
                end
                else if (stat.out_free)
                begin
                    state_next = bfr_pkg::S_IDLE;
                end
            end
            bfr_pkg::S_SCAN:
            begin
                if (stat.scan_stop)
                begin
                    state_next = bfr_pkg::S_HEAD;
                end
            end
            bfr_pkg::S_HEAD:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.run_zero ? bfr_pkg::S_IDLE : bfr_pkg::S_DRAIN_EMIT;
                end
            end
            bfr_pkg::S_DRAIN_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.drain_last ? bfr_pkg::S_IDLE : bfr_pkg::S_DRAIN_RD;
                end
            end
            bfr_pkg::S_DRAIN_RD:
            begin
                state_next = bfr_pkg::S_DRAIN_EMIT;
            end
            default:
            begin
                state_next = bfr_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            bfr_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            bfr_pkg::S_CLASSIFY:
            begin
                cmd.classify = stat.is_merge || stat.out_free;
            end
            bfr_pkg::S_SCAN:
            begin
                cmd.scan_step   = !stat.scan_stop;
                cmd.scan_finish = stat.scan_stop;
            end
            bfr_pkg::S_HEAD:
            begin
                cmd.head_load = stat.out_free;
            end
            bfr_pkg::S_DRAIN_EMIT:
            begin
                cmd.drain_load = stat.out_free;
            end
            bfr_pkg::S_DRAIN_RD:
            begin
                cmd = '0;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTH
    // A held fragment is only emitted after the scan has fixed the run length
    a_head_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfr_pkg::S_HEAD) && !$past(state_reg == bfr_pkg::S_HEAD)
        |-> $past(cmd.scan_finish))
        else $error("head result without a finished scan");

    // A captured input always moves on to classification
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == bfr_pkg::S_CLASSIFY))
        else $error("capture did not lead to classification");

    // A drain read bubble always returns to emission
    a_drain_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfr_pkg::S_DRAIN_RD) |=> (state_reg == bfr_pkg::S_DRAIN_EMIT))
        else $error("drain read did not return to emit");
`endif

endmodule

@@ design/bfr_datapath.sv @@
// Datapath for burst fragment reassembly: burst state, reorder store (valid bits plus
// a slot memory), run scan counter and the output register. Depends on bfr_pkg.
module bfr_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  bfr_pkg::frag_in_t  in_data,
    output bfr_pkg::frag_out_t out_data,
    output logic               out_valid,
    input  logic               out_ready,
    input  bfr_pkg::ctrl_cmd_t cmd,
    output bfr_pkg::dp_stat_t  stat
);

    typedef struct packed {
        logic [bfr_pkg::HANDLE_BITS-1:0] handle;
        logic [15:0]                     len;
    } slot_entry_t;

    // Saturating byte accumulate
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {17'd0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Registers
    bfr_pkg::frag_in_t                    in_reg, in_next;
    logic [31:0]                          cur_reg, cur_next;
    logic [15:0]                          mc_reg, mc_next;
    logic [31:0]                          bytes_reg, bytes_next;
    logic [bfr_pkg::REORDER_DEPTH-1:0]    valid_reg, valid_next;
    logic [31:0]                          ftot_reg, ftot_next;
    logic [31:0]                          btot_reg, btot_next;
    bfr_pkg::frag_out_t                   head_reg, head_next;
    logic                                 complete_reg, complete_next;
    logic [bfr_pkg::SLOT_BITS-1:0]        scan_cnt_reg, scan_cnt_next;
    logic [bfr_pkg::SLOT_BITS-1:0]        remain_reg, remain_next;
    logic                                 out_valid_reg, out_valid_next;
    bfr_pkg::frag_out_t                   out_reg, out_next;
    slot_entry_t                          rd_reg;

    slot_entry_t slot_mem [bfr_pkg::REORDER_DEPTH];

    // Classification signals
    logic                          is_empty, is_stale, is_new, is_live;
    logic                          hit_old, hit_merge, out_win, hit_parked, do_park;
    logic                          complete_now, out_load, mem_we;
    logic [15:0]                   mc_eff, idx_gap, final_mc;
    logic [31:0]                   bytes_eff;
    logic [bfr_pkg::SLOT_BITS-1:0] in_slot, mc_slot, scan_slot;
    bfr_pkg::status_t              cls_status;
    logic [31:0]                   btot_now;

    // Classify the held fragment against the burst state
    always_comb
    begin
        is_empty   = (in_reg.frag_len == 16'd0);
        is_stale   = !is_empty && (in_reg.burst_seq < cur_reg);
        is_new     = !is_empty && (in_reg.burst_seq > cur_reg);
        is_live    = !is_empty && !is_stale;
        mc_eff     = is_new ? 16'd0 : mc_reg;
        bytes_eff  = is_new ? 32'd0 : bytes_reg;
        in_slot    = in_reg.frag_index[bfr_pkg::SLOT_BITS-1:0];
        mc_slot    = mc_reg[bfr_pkg::SLOT_BITS-1:0];
        scan_slot  = mc_slot + scan_cnt_reg;
        idx_gap    = in_reg.frag_index - mc_eff;
        hit_old    = (in_reg.frag_index < mc_eff);
        hit_merge  = (in_reg.frag_index == mc_eff);
        out_win    = (idx_gap >= 16'(bfr_pkg::REORDER_DEPTH));
        hit_parked = !is_new && valid_reg[in_slot];

        if (is_empty)
            cls_status = bfr_pkg::ST_EMPTY;
        else if (is_stale)
            cls_status = bfr_pkg::ST_STALE;
        else if (hit_old)
            cls_status = bfr_pkg::ST_DUP;
        else if (hit_merge)
            cls_status = bfr_pkg::ST_MERGED;
        else if (out_win)
            cls_status = bfr_pkg::ST_WINDOW;
        else if (hit_parked)
            cls_status = bfr_pkg::ST_DUP;
        else
            cls_status = bfr_pkg::ST_PARKED;

        do_park      = is_live && (cls_status == bfr_pkg::ST_PARKED);
        complete_now = is_live && (mc_eff == in_reg.frag_count);
        btot_now     = btot_reg + {31'd0, complete_now};
        final_mc     = mc_reg + 16'(scan_cnt_reg);
        mem_we       = cmd.classify && do_park;
        out_load     = (cmd.classify && !(is_live && hit_merge)) || cmd.head_load
                       || cmd.drain_load;
    end

    // Status to controller
    always_comb
    begin
        stat.is_merge   = is_live && hit_merge;
        stat.scan_stop  = !valid_reg[scan_slot]
                          || (scan_cnt_reg == bfr_pkg::SLOT_BITS'(bfr_pkg::REORDER_DEPTH - 1));
        stat.run_zero   = (remain_reg == '0);
        stat.drain_last = (remain_reg == bfr_pkg::SLOT_BITS'(1));
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Next values
    always_comb
    begin
        in_next        = in_reg;
        cur_next       = cur_reg;
        mc_next        = mc_reg;
        bytes_next     = bytes_reg;
        valid_next     = valid_reg;
        ftot_next      = ftot_reg;
        btot_next      = btot_reg;
        head_next      = head_reg;
        complete_next  = complete_reg;
        scan_cnt_next  = scan_cnt_reg;
        remain_next    = remain_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        // Capture the input transaction
        if (cmd.capture)
        begin
            in_next = in_data;
        end

        // Apply the fragment: new burst reset, park, merge or drop
        if (cmd.classify)
        begin
            if (!is_empty)
            begin
                ftot_next = ftot_reg + 32'd1;
            end
            if (is_new)
            begin
                cur_next   = in_reg.burst_seq;
                mc_next    = 16'd0;
                bytes_next = 32'd0;
                valid_next = '0;
            end
            if (do_park)
            begin
                valid_next[in_slot] = 1'b1;
            end
            if (is_live && hit_merge)
            begin
                mc_next                      = in_reg.frag_index + 16'd1;
                bytes_next                   = sat_add(bytes_eff, in_reg.frag_len);
                scan_cnt_next                = '0;
                head_next                    = '0;
                head_next.status             = bfr_pkg::ST_MERGED;
                head_next.out_index          = in_reg.frag_index;
                head_next.out_handle         = in_reg.frag_handle;
                head_next.out_len            = in_reg.frag_len;
                head_next.merged_so_far      = in_reg.frag_index + 16'd1;
                head_next.merged_total_bytes = sat_add(bytes_eff, in_reg.frag_len);
            end
            else
            begin
                btot_next                   = btot_now;
                out_next.status             = cls_status;
                out_next.out_index          = in_reg.frag_index;
                out_next.out_handle         = '0;
                out_next.out_len            = 16'd0;
                out_next.out_burst          = is_new ? in_reg.burst_seq : cur_reg;
                out_next.merged_so_far      = mc_eff;
                out_next.merged_total_bytes = bytes_eff;
                out_next.burst_complete     = complete_now;
                out_next.last               = 1'b1;
                out_next.fragments_seen     = is_empty ? ftot_reg : ftot_reg + 32'd1;
                out_next.bursts_done        = btot_now;
            end
        end

        // Count the run of parked fragments that follow in order
        if (cmd.scan_step)
        begin
            scan_cnt_next = scan_cnt_reg + bfr_pkg::SLOT_BITS'(1);
        end
        if (cmd.scan_finish)
        begin
            complete_next = (final_mc == in_reg.frag_count);
            btot_next     = btot_reg + {31'd0, (final_mc == in_reg.frag_count)};
            remain_next   = scan_cnt_reg;
        end

        // Emit the fragment that arrived in order
        if (cmd.head_load)
        begin
            out_next                = head_reg;
            out_next.out_burst      = cur_reg;
            out_next.fragments_seen = ftot_reg;
            out_next.bursts_done    = btot_reg;
            out_next.last           = stat.run_zero;
            out_next.burst_complete = complete_reg && stat.run_zero;
        end

        // Release one parked fragment from the store
        if (cmd.drain_load)
        begin
            mc_next                     = mc_reg + 16'd1;
            bytes_next                  = sat_add(bytes_reg, rd_reg.len);
            valid_next[mc_slot]         = 1'b0;
            remain_next                 = remain_reg - bfr_pkg::SLOT_BITS'(1);
            out_next.status             = bfr_pkg::ST_MERGED;
            out_next.out_index          = mc_reg;
            out_next.out_handle         = rd_reg.handle;
            out_next.out_len            = rd_reg.len;
            out_next.out_burst          = cur_reg;
            out_next.merged_so_far      = mc_reg + 16'd1;
            out_next.merged_total_bytes = sat_add(bytes_reg, rd_reg.len);
            out_next.burst_complete     = complete_reg && stat.drain_last;
            out_next.last               = stat.drain_last;
            out_next.fragments_seen     = ftot_reg;
            out_next.bursts_done        = btot_reg;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            mc_reg        <= '0;
            bytes_reg     <= '0;
            valid_reg     <= '0;
            ftot_reg      <= '0;
            btot_reg      <= '0;
            complete_reg  <= 1'b0;
            scan_cnt_reg  <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            mc_reg        <= mc_next;
            bytes_reg     <= bytes_next;
            valid_reg     <= valid_next;
            ftot_reg      <= ftot_next;
            btot_reg      <= btot_next;
            complete_reg  <= complete_next;
            scan_cnt_reg  <= scan_cnt_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        head_reg <= head_next;
        out_reg  <= out_next;
    end

    // Slot memory: park writes, registered read at the next expected slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[in_slot] <= '{handle: in_reg.frag_handle, len: in_reg.frag_len};
        end
        rd_reg <= slot_mem[mc_slot];
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

`ifndef SYNTH
    // Only parked slots are drained
    a_drain_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_load |-> valid_reg[mc_slot])
        else $error("drain of an empty slot");

    // Each drained fragment advances the merge point by one
    a_drain_adv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_load |=> (mc_reg == $past(mc_reg) + 16'd1))
        else $error("merge count did not advance on drain");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // The scan only steps over parked slots
    a_scan_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> valid_reg[scan_slot])
        else $error("scan stepped over an empty slot");
`endif

endmodule

@@ design/burst_fragment_reassembly.sv @@
// Top level of burst fragment reassembly: joins the controller and the datapath.
// Depends on bfr_pkg, bfr_ctrl and bfr_datapath.
//
// Usage: fragment descriptors enter on in_valid/in_ready/in_data; results leave on
// out_valid/out_ready/out_data, one transaction per result, in merge order. Each input
// gives one result, or, when it is the next expected fragment, one result for itself
// plus one for every parked fragment that now follows in order (up to 64 in total).
// The final result of an input has last set.
// Sequence: an input that is not merged (empty, stale, duplicate, out of window,
// parked) passes through acceptance, then classification, which loads its result
// into the output register once that register is free. A merged input first scans the
// valid bits of the reorder store one slot a cycle to size the in-order run r, so that
// completion and the burst counter are known before the first result leaves; it then
// emits its own result and releases each parked fragment in turn, with a read bubble
// between releases for the registered read port of the slot memory.
// Stall: the output register holds a result until taken; the block accepts the next
// input while a result waits, and pauses only when it must load a new result.
// Reset clears the burst state, counters and valid bits at once; no clearing pass.
module burst_fragment_reassembly (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bfr_pkg::frag_in_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bfr_pkg::frag_out_t out_data
);

    bfr_pkg::ctrl_cmd_t cmd;
    bfr_pkg::dp_stat_t  stat;

    // Sequencer
    bfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Burst state, reorder store and result register
    bfr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
